// ===== rtl/dcp_pkg.sv =====
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared types and constants of the display command parser: ASCII codes,
// status codes, parser phases, register map and inter-module structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcp_pkg;

  // ASCII codes of the command bytes
  localparam logic [7:0] CH_C    = 8'h63;  // 'c'
  localparam logic [7:0] CH_P    = 8'h70;  // 'p'
  localparam logic [7:0] CH_L    = 8'h6C;  // 'l'
  localparam logic [7:0] CH_R    = 8'h72;  // 'r'
  localparam logic [7:0] CH_V    = 8'h76;  // 'v'
  localparam logic [7:0] CH_I    = 8'h69;  // 'i'
  localparam logic [7:0] CH_Y    = 8'h79;  // 'y'
  localparam logic [7:0] CH_N    = 8'h6E;  // 'n'
  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE = 8'h39;  // '9'

  // Indicator status codes
  localparam logic [1:0] ST_PRE = 2'd0;
  localparam logic [1:0] ST_OFF = 2'd1;
  localparam logic [1:0] ST_ON  = 2'd2;

  // Item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Register map: index taken from paddr[2]
  localparam int unsigned CFG_AW      = 3;
  localparam int unsigned CFG_DW      = 32;
  localparam int unsigned BEEP_W      = 10;
  localparam logic        REG_ON_TICKS = 1'b0;
  localparam logic        REG_PERIOD   = 1'b1;

  localparam logic [BEEP_W-1:0] ON_TICKS_RST = 10'd500;
  localparam logic [BEEP_W-1:0] PERIOD_RST   = 10'd1000;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_MODE  = 3'd1,
    PH_VALUE = 3'd2,
    PH_D0    = 3'd3,
    PH_D1    = 3'd4,
    PH_D2    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    MODE_C = 3'd0,
    MODE_P = 3'd1,
    MODE_L = 3'd2,
    MODE_R = 3'd3,
    MODE_V = 3'd4
  } mode_t;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [BEEP_W-1:0] on_ticks;
    logic [BEEP_W-1:0] period;
    logic              period_wr;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [1:0]  left_status;
    logic [1:0]  right_status;
    logic [1:0]  car_status;
    logic [1:0]  people_status;
    logic [9:0]  speed;
    logic        command_done;
    logic        beep_level;
  } res_t;

endpackage

// ===== rtl/dcp_cfg.sv =====
// ----------------------------------------------------------------------------
// dcp_cfg
// APB-style register file holding the beeper on-ticks and period settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcp_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dcp_pkg::CFG_AW-1:0]  paddr,
  input  logic [dcp_pkg::CFG_DW-1:0]  pwdata,
  output logic [dcp_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output dcp_pkg::cfg_t               cfg
);
  import dcp_pkg::*;

  logic [BEEP_W-1:0] on_ticks_r;
  logic [BEEP_W-1:0] period_r;
  logic              wr_en;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Write the addressed register in the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_ticks_r <= ON_TICKS_RST;
      period_r   <= PERIOD_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ON_TICKS: on_ticks_r <= pwdata[BEEP_W-1:0];
        REG_PERIOD:   period_r   <= pwdata[BEEP_W-1:0];
        default:      on_ticks_r <= on_ticks_r;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_ON_TICKS: prdata[BEEP_W-1:0] = on_ticks_r;
      REG_PERIOD:   prdata[BEEP_W-1:0] = period_r;
      default:      prdata = '0;
    endcase
  end

  assign cfg.on_ticks  = on_ticks_r;
  assign cfg.period    = period_r;
  assign cfg.period_wr = wr_en & (reg_sel == REG_PERIOD);

endmodule

// ===== rtl/dcp_rem.sv =====
// ----------------------------------------------------------------------------
// dcp_rem
// Bit-serial restoring remainder unit: reduces the beeper count modulo a
// newly written period, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcp_rem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dcp_pkg::BEEP_W-1:0] dividend,
  input  logic [dcp_pkg::BEEP_W-1:0] period,
  output logic                       busy,
  output logic                       done,
  output logic [dcp_pkg::BEEP_W-1:0] result
);
  import dcp_pkg::*;

  localparam int unsigned STEP_W = $clog2(BEEP_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [BEEP_W-1:0] dvd_r;
  logic [BEEP_W:0]   rem_r;
  logic [BEEP_W:0]   divisor;
  logic [BEEP_W:0]   trial;
  logic [BEEP_W:0]   rem_nxt;

  // A period of zero acts as the full counter range
  assign divisor = (period == '0) ? (BEEP_W+1)'(1 << BEEP_W) : {1'b0, period};

  // Shift in the next dividend bit and subtract when it fits
  assign trial   = {rem_r[BEEP_W-1:0], dvd_r[BEEP_W-1]};
  assign rem_nxt = (trial >= divisor) ? (trial - divisor) : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == STEP_W'(BEEP_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Payload: dividend shifter and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[BEEP_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign busy   = busy_r | done_r;
  assign done   = done_r;
  assign result = rem_r[BEEP_W-1:0];

endmodule

// ===== rtl/dcp_core.sv =====
// ----------------------------------------------------------------------------
// dcp_core
// Command parser and beeper state: updates all status registers for one
// item and presents the resulting status set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcp_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       kind,
  input  logic [7:0]                 rx_byte,
  input  dcp_pkg::cfg_t              cfg,
  input  logic                       rem_done,
  input  logic [dcp_pkg::BEEP_W-1:0] rem_result,
  output logic [dcp_pkg::BEEP_W-1:0] beep_count,
  output dcp_pkg::res_t              res
);
  import dcp_pkg::*;

  phase_t            phase_r,  phase_nxt;
  mode_t             mode_r,   mode_nxt;
  logic [3:0]        first_r,  first_nxt;
  logic [3:0]        second_r, second_nxt;
  logic [1:0]        left_r,   left_nxt;
  logic [1:0]        right_r,  right_nxt;
  logic [1:0]        car_r,    car_nxt;
  logic [1:0]        people_r, people_nxt;
  logic [9:0]        speed_r,  speed_nxt;
  logic [BEEP_W-1:0] count_r,  count_nxt;
  logic [BEEP_W-1:0] crem_r,   crem_nxt;
  logic              beep_r,   beep_nxt;
  logic              done;

  logic              is_byte;
  logic              is_tick;
  logic              is_mode;
  mode_t             scan_mode;
  phase_t            scan_phase;
  logic              is_digit;
  logic [3:0]        digit;
  logic [1:0]        value_st;
  logic [9:0]        speed_calc;
  logic              beep_active;
  logic [BEEP_W:0]   count_inc;
  logic [BEEP_W:0]   crem_inc;
  logic [BEEP_W:0]   period_ext;

  assign is_byte = step & (kind == KIND_BYTE);
  assign is_tick = step & (kind == KIND_TICK);

  // Decode the byte as a possible mode byte
  always_comb begin
    is_mode   = 1'b1;
    scan_mode = MODE_C;
    unique case (rx_byte)
      CH_C:    scan_mode = MODE_C;
      CH_P:    scan_mode = MODE_P;
      CH_L:    scan_mode = MODE_L;
      CH_R:    scan_mode = MODE_R;
      CH_V:    scan_mode = MODE_V;
      default: is_mode   = 1'b0;
    endcase
  end

  assign scan_phase = is_mode ? PH_MODE : PH_IDLE;
  assign is_digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit      = rx_byte[3:0];
  assign value_st   = (rx_byte == CH_Y) ? ST_ON : (rx_byte == CH_N) ? ST_OFF : ST_PRE;
  assign speed_calc = 10'(first_r) * 10'd100 + 10'(second_r) * 10'd10 + 10'(digit);

  // Next parser phase and pending mode
  always_comb begin
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    if (is_byte) begin
      unique case (phase_r)
        PH_MODE: begin
          if (rx_byte == CH_I) begin
            phase_nxt = PH_VALUE;
          end else begin
            phase_nxt = scan_phase;
            if (is_mode) mode_nxt = scan_mode;
          end
        end
        PH_VALUE: begin
          phase_nxt = (mode_r == MODE_V) ? PH_D0 : PH_IDLE;
        end
        PH_D0: begin
          if (is_digit) begin
            phase_nxt = PH_D1;
          end else begin
            phase_nxt = scan_phase;
            if (is_mode) mode_nxt = scan_mode;
          end
        end
        PH_D1: begin
          if (is_digit) begin
            phase_nxt = PH_D2;
          end else begin
            phase_nxt = scan_phase;
            if (is_mode) mode_nxt = scan_mode;
          end
        end
        PH_D2: begin
          if (is_digit) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = scan_phase;
            if (is_mode) mode_nxt = scan_mode;
          end
        end
        default: begin
          phase_nxt = scan_phase;
          if (is_mode) mode_nxt = scan_mode;
        end
      endcase
    end
  end

  // Indicator, digit and speed updates from the parser phase
  always_comb begin
    first_nxt  = first_r;
    second_nxt = second_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    car_nxt    = car_r;
    people_nxt = people_r;
    speed_nxt  = speed_r;
    done       = 1'b0;
    if (is_byte) begin
      unique case (phase_r)
        PH_VALUE: begin
          if (mode_r != MODE_V) begin
            done = 1'b1;
            unique case (mode_r)
              MODE_C:  car_nxt    = value_st;
              MODE_P:  people_nxt = value_st;
              MODE_L:  left_nxt   = value_st;
              default: right_nxt  = value_st;
            endcase
          end
        end
        PH_D0: begin
          if (is_digit) first_nxt = digit;
        end
        PH_D1: begin
          if (is_digit) second_nxt = digit;
        end
        PH_D2: begin
          if (is_digit) begin
            speed_nxt = speed_calc;
            done      = 1'b1;
          end
        end
        default: done = 1'b0;
      endcase
    end
  end

  // Beeper: toggle while the raw count is inside the on window, wrap the
  // reduced count at the period
  assign beep_active = (car_r == ST_ON) || (people_r == ST_ON);
  assign count_inc   = {1'b0, count_r} + 1'b1;
  assign crem_inc    = {1'b0, crem_r} + 1'b1;
  assign period_ext  = (cfg.period == '0) ? (BEEP_W+1)'(1 << BEEP_W) : {1'b0, cfg.period};

  always_comb begin
    count_nxt = count_r;
    crem_nxt  = crem_r;
    beep_nxt  = beep_r;
    if (rem_done) begin
      crem_nxt = rem_result;
    end else if (is_tick) begin
      if (beep_active) begin
        beep_nxt  = (count_inc < {1'b0, cfg.on_ticks}) ? ~beep_r : 1'b0;
        count_nxt = (crem_inc == period_ext) ? '0 : crem_inc[BEEP_W-1:0];
        crem_nxt  = count_nxt;
      end else begin
        count_nxt = '0;
        crem_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      mode_r   <= MODE_C;
      first_r  <= '0;
      second_r <= '0;
      left_r   <= ST_ON;
      right_r  <= ST_ON;
      car_r    <= ST_OFF;
      people_r <= ST_OFF;
      speed_r  <= '0;
      count_r  <= '0;
      crem_r   <= '0;
      beep_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      mode_r   <= mode_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      car_r    <= car_nxt;
      people_r <= people_nxt;
      speed_r  <= speed_nxt;
      count_r  <= count_nxt;
      crem_r   <= crem_nxt;
      beep_r   <= beep_nxt;
    end
  end

  assign beep_count = count_r;

  // Status set after this item
  assign res.left_status   = left_nxt;
  assign res.right_status  = right_nxt;
  assign res.car_status    = car_nxt;
  assign res.people_status = people_nxt;
  assign res.speed         = speed_nxt;
  assign res.command_done  = done;
  assign res.beep_level    = beep_nxt;

endmodule

// ===== rtl/display_command_parser.sv =====
// ----------------------------------------------------------------------------
// display_command_parser
// Streaming ASCII command parser for display indicators, speed and beeper.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one item per handshake, either a
//   received byte (in_kind = 0, in_rx_byte) or a timer tick (in_kind = 1).
//   Result channel (out_valid/out_ready): exactly one result per item,
//   carrying all four indicator statuses, the speed, a command-done flag
//   and the beeper level.
//   Configuration: APB-style port, beep_on_ticks at 0x0, beep_period at 0x4.
//   A taken item sits in the input register, is processed and loaded into
//   the result register, whose out_valid then offers it to the receiver;
//   throughput is one item per cycle while the receiver keeps up and no
//   remainder pass is running.
//   Writing beep_period starts a bit-serial remainder pass over the beeper
//   count, one bit per cycle; in_ready stays low while the pass runs.
//   A stalled receiver holds the result register; one further item waits in
//   the input register, after which in_ready drops.
//   Reset (rst_n low, synchronous) empties both registers, sets left/right
//   on, car/people off, speed and beeper count zero, and restores the
//   register defaults 500 and 1000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module display_command_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  logic [7:0]                 in_rx_byte,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_left_status,
  output logic [1:0]                 out_right_status,
  output logic [1:0]                 out_car_status,
  output logic [1:0]                 out_people_status,
  output logic [9:0]                 out_speed,
  output logic                       out_command_done,
  output logic                       out_beep_level,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dcp_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import dcp_pkg::*;

  cfg_t              cfg;
  res_t              res;
  logic              s1_valid_r;
  logic              s1_kind_r;
  logic [7:0]        s1_byte_r;
  logic              out_valid_r;
  res_t              out_r;
  logic              out_free;
  logic              step;
  logic              rem_busy;
  logic              rem_done;
  logic [BEEP_W-1:0] rem_result;
  logic [BEEP_W-1:0] beep_count;

  dcp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dcp_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cfg.period_wr),
    .dividend (beep_count),
    .period   (cfg.period),
    .busy     (rem_busy),
    .done     (rem_done),
    .result   (rem_result)
  );

  dcp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .kind       (s1_kind_r),
    .rx_byte    (s1_byte_r),
    .cfg        (cfg),
    .rem_done   (rem_done),
    .rem_result (rem_result),
    .beep_count (beep_count),
    .res        (res)
  );

  // Handshake: process the held item when the result register can take it
  assign out_free = ~out_valid_r | out_ready;
  assign step     = s1_valid_r & out_free;
  assign in_ready = ~rem_busy & (~s1_valid_r | out_free);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_rx_byte;
    end
  end

  // Result register: load on step, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_status   = out_r.left_status;
  assign out_right_status  = out_r.right_status;
  assign out_car_status    = out_r.car_status;
  assign out_people_status = out_r.people_status;
  assign out_speed         = out_r.speed;
  assign out_command_done  = out_r.command_done;
  assign out_beep_level    = out_r.beep_level;

endmodule

// ===== bench/display_command_parser_checker.sv =====
// ----------------------------------------------------------------------------
// display_command_parser_checker
// Watches the input, result and configuration ports of the command parser,
// keeps its own copy of the parser, indicator and beeper state, predicts one
// result per accepted item and compares every accepted result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module display_command_parser_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_kind,
  input  logic [7:0]                 in_rx_byte,
  // result channel
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [1:0]                 out_left_status,
  input  logic [1:0]                 out_right_status,
  input  logic [1:0]                 out_car_status,
  input  logic [1:0]                 out_people_status,
  input  logic [9:0]                 out_speed,
  input  logic                       out_command_done,
  input  logic                       out_beep_level,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [dcp_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  // verdict
  output int                         mismatches,
  output int                         outstanding
);
  import dcp_pkg::*;

  // Statuses still owed by the block, oldest first
  res_t status_q[$];

  // Beeper settings as last written
  logic [BEEP_W-1:0] on_ticks;
  logic [BEEP_W-1:0] beep_period;

  // Parser and display state
  phase_t            phase;
  mode_t             mode;
  logic [3:0]        hundreds_digit;
  logic [3:0]        tens_digit;
  logic [1:0]        left_st;
  logic [1:0]        right_st;
  logic [1:0]        car_st;
  logic [1:0]        people_st;
  logic [9:0]        speed_val;
  logic [BEEP_W-1:0] beep_count;
  logic              beep;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // Look at a byte as the start of a new command
  function automatic void scan_mode(input logic [7:0] b);
    phase = PH_MODE;
    if (b == CH_C) mode = MODE_C;
    else if (b == CH_P) mode = MODE_P;
    else if (b == CH_L) mode = MODE_L;
    else if (b == CH_R) mode = MODE_R;
    else if (b == CH_V) mode = MODE_V;
    else phase = PH_IDLE;
  endfunction

  // Advance the parser by one byte; return high when a command completes
  function automatic logic parse_byte(input logic [7:0] b);
    logic       done;
    logic [1:0] setting;
    done = 1'b0;
    case (phase)
      PH_MODE: begin
        if (b == CH_I) phase = PH_VALUE;
        else scan_mode(b);
      end
      PH_VALUE: begin
        if (mode == MODE_V) begin
          // skip the filler byte of a speed command
          phase = PH_D0;
        end else begin
          setting = (b == CH_Y) ? ST_ON : (b == CH_N) ? ST_OFF : ST_PRE;
          case (mode)
            MODE_C:  car_st = setting;
            MODE_P:  people_st = setting;
            MODE_L:  left_st = setting;
            default: right_st = setting;
          endcase
          phase = PH_IDLE;
          done = 1'b1;
        end
      end
      PH_D0: begin
        if (!is_digit(b)) begin
          scan_mode(b);
        end else begin
          hundreds_digit = 4'(b - CH_ZERO);
          phase = PH_D1;
        end
      end
      PH_D1: begin
        if (!is_digit(b)) begin
          scan_mode(b);
        end else begin
          tens_digit = 4'(b - CH_ZERO);
          phase = PH_D2;
        end
      end
      PH_D2: begin
        if (!is_digit(b)) begin
          scan_mode(b);
        end else begin
          speed_val = 10'(int'(hundreds_digit) * 100 + int'(tens_digit) * 10
                          + int'(b - CH_ZERO));
          phase = PH_IDLE;
          done = 1'b1;
        end
      end
      default: scan_mode(b);
    endcase
    return done;
  endfunction

  // Advance the beeper by one timer tick
  function automatic void beep_tick();
    logic [BEEP_W:0] count_up;
    logic [BEEP_W:0] wrap;
    if (car_st == ST_ON || people_st == ST_ON) begin
      count_up = {1'b0, beep_count} + 1'b1;
      if (count_up < {1'b0, on_ticks}) beep = ~beep;
      else beep = 1'b0;
      // a zero period wraps at the natural width of the counter
      wrap = (beep_period == '0) ? (BEEP_W + 1)'(1 << BEEP_W) : {1'b0, beep_period};
      beep_count = BEEP_W'(count_up % wrap);
    end else begin
      beep_count = '0;
    end
  endfunction

  function automatic res_t predict_status(input logic kind, input logic [7:0] b);
    res_t r;
    logic done;
    done = 1'b0;
    if (kind == KIND_TICK) beep_tick();
    else done = parse_byte(b);
    r.left_status   = left_st;
    r.right_status  = right_st;
    r.car_status    = car_st;
    r.people_status = people_st;
    r.speed         = speed_val;
    r.command_done  = done;
    r.beep_level    = beep;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Follow the block on every rising edge: results first, then writes and items
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      status_q.delete();
      on_ticks       = ON_TICKS_RST;
      beep_period    = PERIOD_RST;
      phase          = PH_IDLE;
      mode           = MODE_C;
      hundreds_digit = '0;
      tens_digit     = '0;
      left_st        = ST_ON;
      right_st       = ST_ON;
      car_st         = ST_OFF;
      people_st      = ST_OFF;
      speed_val      = '0;
      beep_count     = '0;
      beep           = 1'b0;
    end else begin
      // compare an accepted result with the oldest prediction
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          $error("result item arrived with no item outstanding");
          mismatches++;
        end else begin
          want = status_q.pop_front();
          check_field("left_status", want.left_status, out_left_status);
          check_field("right_status", want.right_status, out_right_status);
          check_field("car_status", want.car_status, out_car_status);
          check_field("people_status", want.people_status, out_people_status);
          check_field("speed", want.speed, out_speed);
          check_field("command_done", want.command_done, out_command_done);
          check_field("beep_level", want.beep_level, out_beep_level);
        end
      end
      // track register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_PERIOD) beep_period = pwdata[BEEP_W-1:0];
        else on_ticks = pwdata[BEEP_W-1:0];
      end
      // predict the status for an accepted item
      if (in_valid && in_ready) status_q.push_back(predict_status(in_kind, in_rx_byte));
    end
    outstanding = status_q.size();
  end

endmodule

// ===== bench/display_command_parser_tb.sv =====
// ----------------------------------------------------------------------------
// display_command_parser_tb
// Drives received bytes and timer ticks into the command parser in random
// bursts against a stalling receiver, reprograms the beeper between phases
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module display_command_parser_tb;
  import dcp_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 8;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_kind;
  logic [7:0]        in_rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_left_status;
  logic [1:0]        out_right_status;
  logic [1:0]        out_car_status;
  logic [1:0]        out_people_status;
  logic [9:0]        out_speed;
  logic              out_command_done;
  logic              out_beep_level;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                mismatches;
  int                outstanding;
  int                burst_left;
  int unsigned       cycle_count;

  display_command_parser dut (.*);

  display_command_parser_checker checker_i (.*);

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Abandon a run that hangs
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: cycle through always ready, random, periodic and heavy stalls
  initial begin
    int stall_step;
    stall_step = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      stall_step++;
      case ((stall_step / 64) % 4)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= (stall_step % 5) != 0;
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offer one item, opening a gap whenever a burst runs out
  task automatic send_item(input logic kind, input logic [7:0] data);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_rx_byte <= data;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
  endtask

  // Hold the sender until every status has come back, then let the block settle
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic index, input logic [BEEP_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {{(32 - BEEP_W){1'b0}}, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] mode_letter(input bit with_speed);
    case ($urandom_range(0, with_speed ? 4 : 3))
      0:       return CH_C;
      1:       return CH_P;
      2:       return CH_L;
      3:       return CH_R;
      default: return CH_V;
    endcase
  endfunction

  function automatic logic [7:0] digit_byte();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // A byte that may break a command: a mode letter, an 'i' or anything at all
  function automatic logic [7:0] junk_byte();
    case ($urandom_range(0, 2))
      0:       return mode_letter(1'b1);
      1:       return CH_I;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed commands with random content, plus ticks, breaks and noise
  task automatic random_items(input int count);
    int         sent;
    int         pick;
    int         reps;
    logic [7:0] value;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        reps = $urandom_range(1, 6);
        repeat (reps) send_item(KIND_TICK, 8'($urandom));
        sent += reps;
      end else if (pick < 58) begin
        reps = $urandom_range(0, 9);
        value = (reps < 4) ? CH_Y : (reps < 7) ? CH_N : 8'($urandom);
        send_item(KIND_BYTE, mode_letter(1'b0));
        send_item(KIND_BYTE, CH_I);
        send_item(KIND_BYTE, value);
        sent += 3;
      end else if (pick < 78) begin
        send_item(KIND_BYTE, CH_V);
        send_item(KIND_BYTE, CH_I);
        send_item(KIND_BYTE, 8'($urandom));
        repeat (3) send_item(KIND_BYTE, digit_byte());
        sent += 6;
      end else if (pick < 90) begin
        // broken command: cut after the mode letter or part way through a speed
        if ($urandom_range(0, 1) == 0) begin
          send_item(KIND_BYTE, mode_letter(1'b1));
          send_item(KIND_BYTE, junk_byte());
          sent += 2;
        end else begin
          reps = $urandom_range(0, 2);
          send_item(KIND_BYTE, CH_V);
          send_item(KIND_BYTE, CH_I);
          send_item(KIND_BYTE, 8'($urandom));
          repeat (reps) send_item(KIND_BYTE, digit_byte());
          send_item(KIND_BYTE, junk_byte());
          sent += 4 + reps;
        end
      end else begin
        send_item(KIND_BYTE, 8'($urandom));
        sent += 1;
      end
    end
  endtask

  task automatic run_phase(input logic [BEEP_W-1:0] on_val,
                           input logic [BEEP_W-1:0] period_val, input int count);
    wait_until_drained();
    write_register(REG_ON_TICKS, on_val);
    write_register(REG_PERIOD, period_val);
    random_items(count);
  endtask

  // Stimulus
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_kind    = KIND_BYTE;
    in_rx_byte = 8'h00;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    burst_left = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // stray byte while idle, then a tick with car and people off
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_TICK, 8'h00);
    // car on, then ticks toggle the beeper
    send_item(KIND_BYTE, CH_C); send_item(KIND_BYTE, CH_I); send_item(KIND_BYTE, CH_Y);
    send_item(KIND_TICK, 8'hFF); send_item(KIND_TICK, 8'h55);
    // speed whose filler byte is a mode letter
    send_item(KIND_BYTE, CH_V); send_item(KIND_BYTE, CH_I); send_item(KIND_BYTE, CH_V);
    send_item(KIND_BYTE, CH_NINE); send_item(KIND_BYTE, CH_ZERO);
    send_item(KIND_BYTE, CH_NINE);
    // missing 'i': the breaking byte starts a people-off command
    send_item(KIND_BYTE, CH_R); send_item(KIND_BYTE, CH_P); send_item(KIND_BYTE, CH_I);
    send_item(KIND_BYTE, CH_N);
    // left set to keep-previous by an unknown value byte
    send_item(KIND_BYTE, CH_L); send_item(KIND_BYTE, CH_I); send_item(KIND_BYTE, 8'h00);
    // non-digit in a speed restarts as car off
    send_item(KIND_BYTE, CH_V); send_item(KIND_BYTE, CH_I); send_item(KIND_BYTE, 8'h61);
    send_item(KIND_BYTE, CH_C); send_item(KIND_BYTE, CH_I); send_item(KIND_BYTE, CH_N);
    random_items(150);

    // short periods, then the extremes of both registers
    run_phase(10'd3, 10'd7, 300);
    run_phase(10'd0, 10'd1, 200);
    run_phase(10'd1023, 10'd0, 250);
    run_phase(10'd12, 10'd5, 200);

    // let the counter climb, then drop the period below it
    wait_until_drained();
    write_register(REG_ON_TICKS, 10'd600);
    write_register(REG_PERIOD, 10'd1023);
    send_item(KIND_BYTE, CH_C); send_item(KIND_BYTE, CH_I); send_item(KIND_BYTE, CH_Y);
    repeat (40) send_item(KIND_TICK, 8'($urandom));
    wait_until_drained();
    write_register(REG_ON_TICKS, 10'd4);
    write_register(REG_PERIOD, 10'd6);
    random_items(200);

    run_phase(10'd1, 10'd1023, 150);

    wait_until_drained();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
